// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression does not hold");
// Checks that the consequent holds in the cycle of the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/rau_pkg.sv -----
// Package with item types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  // Width of every component field on the ports.
  localparam int FIELD_BITS = 32;

  // Operation codes.
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_NEG = 4'd4;
  localparam logic [3:0] OP_ABS = 4'd5;
  localparam logic [3:0] OP_LT  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Modes of the shared add and subtract unit.
  localparam logic ALU_ADD     = 1'b0;
  localparam logic ALU_ABSDIFF = 1'b1;

  // Input item.
  typedef struct packed {
    logic [3:0]                   operation;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
  } rau_req_t;

  // Result item.
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic                         cmp_flag;
    logic [1:0]                   status;
  } rau_rsp_t;

  // Flags returned by the shared add and subtract unit.
  typedef struct packed {
    logic geq;
    logic zero;
  } rau_alu_flags_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rau_mul.sv -----
// Sign-magnitude multiplier of two signed words.
`default_nettype none
module rau_mul import rau_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic signed [W-1:0] x,
  input  wire logic signed [W-1:0] y,
  output logic                     neg,
  output logic [2*W-1:0]           mag
);

  localparam int MW = 2 * W;

  logic [W-1:0] x_mag;
  logic [W-1:0] y_mag;

  // Magnitudes; the most negative word maps onto its unsigned magnitude.
  assign x_mag = x[W-1] ? (~x + W'(1)) : x;
  assign y_mag = y[W-1] ? (~y + W'(1)) : y;

  // Sign follows the operand signs, even for a zero product.
  assign neg = x[W-1] ^ y[W-1];
  assign mag = MW'(x_mag) * MW'(y_mag);

endmodule
`default_nettype wire

// ----- hw/rtl/rau_alu.sv -----
// Shared unit that adds, or subtracts the smaller operand from the larger.
`default_nettype none
module rau_alu import rau_pkg::*; #(
  parameter int UW = 65
) (
  input  wire logic          mode,
  input  wire logic [UW-1:0] x,
  input  wire logic [UW-1:0] y,
  output logic [UW-1:0]      res,
  output rau_alu_flags_t     flags
);

  logic          geq;
  logic [UW-1:0] big;
  logic [UW-1:0] sml;

  // Order the operands so that the subtraction never borrows.
  assign geq = (x >= y);
  assign big = geq ? x : y;
  assign sml = geq ? y : x;

  assign res        = (mode == ALU_ADD) ? (x + y) : (big - sml);
  assign flags.geq  = geq;
  assign flags.zero = (res == '0);

endmodule
`default_nettype wire

// ----- hw/rtl/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, datapath registers and result register.
`default_nettype none
`include "assert_macros.svh"
// The unit takes one item at a time and works on it in steps with one
// multiplier and one shared add/subtract unit under a small sequencer; req_stall
// is high from acceptance until the result is loaded into the result register.
// Products are formed one at a time (two to three per item), then an add or a
// compare, and the gcd is found by the binary method on the 2*WORD_BITS-bit
// magnitudes, one shift or one subtraction per cycle. The reduced numerator and
// denominator then come from two restoring divisions, skipped when the gcd is
// one. A comparison ends after its compare, and an item with an unused operation
// or a zero operand denominator goes straight to the final state. Each item is
// held longer while an earlier result still waits, stalled, in the result
// register. A finished result waits in the result register while the next item
// is accepted.
module rational_arith_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire rau_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output rau_rsp_t      rsp
);

  localparam int W  = WORD_BITS;
  localparam int MW = 2 * W;
  localparam int UW = MW + 1;
  localparam int KW = $clog2(MW);
  localparam int CW = $clog2(MW);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MUL3 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_GCD  = 4'd7;
  localparam logic [3:0] S_DIVN = 4'd8;
  localparam logic [3:0] S_DIVD = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]          state;
  logic [3:0]          op;
  logic signed [W-1:0] an;
  logic signed [W-1:0] ad;
  logic signed [W-1:0] bn;
  logic signed [W-1:0] bd;
  logic                num_neg;
  logic [MW-1:0]       num_mag;
  logic                q_neg;
  logic [MW-1:0]       q_mag;
  logic                den_neg;
  logic [MW-1:0]       den_mag;
  logic [MW-1:0]       u;
  logic [MW-1:0]       v;
  logic [KW-1:0]       k;
  logic [MW-1:0]       g;
  logic [MW-1:0]       rem;
  logic [CW-1:0]       cnt;
  logic                pend_zero;
  logic [1:0]          pend_status;
  logic                pend_flag;

  logic                accept;
  logic                slot_free;
  logic                is_unary;
  logic                is_cmp;
  logic                is_addsub;

  logic signed [W-1:0] mul_x;
  logic signed [W-1:0] mul_y;
  logic                prod_neg;
  logic [MW-1:0]       prod_mag;

  logic                alu_mode;
  logic [UW-1:0]       alu_x;
  logic [UW-1:0]       alu_y;
  logic [UW-1:0]       alu_res;
  rau_alu_flags_t      alu_flags;

  logic [UW-1:0]       div_shift;
  logic [MW-1:0]       div_dvd;
  logic [MW-1:0]       gcd_val;
  logic                p_neg;
  logic                r_neg;
  logic                cmp_eq;
  logic                cmp_lt;
  logic                cmp_res;

  logic                out_nneg;
  logic                out_dneg;
  logic signed [W-1:0] out_nlow;
  logic signed [W-1:0] out_dlow;
  logic [W:0]          top_n;
  logic [W:0]          top_d;
  logic                fit_n;
  logic                fit_d;
  rau_rsp_t            rsp_build;

  // Handshake.
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  // Operation classes.
  assign is_unary  = (op == OP_NEG) || (op == OP_ABS);
  assign is_cmp    = (op == OP_LT) || (op == OP_GT) || (op == OP_EQ);
  assign is_addsub = (op == OP_ADD) || (op == OP_SUB);

  // Multiplier operand selection per product step.
  always_comb begin
    mul_x = an;
    mul_y = bd;
    unique case (state)
      S_MUL1: begin
        mul_x = an;
        if (op == OP_MUL) begin
          mul_y = bn;
        end else if (op == OP_NEG) begin
          mul_y = '1;
        end else if (op == OP_ABS) begin
          mul_y = W'(1);
        end else begin
          mul_y = bd;
        end
      end
      S_MUL2: begin
        mul_x = bn;
        mul_y = ad;
      end
      S_MUL3: begin
        mul_x = ad;
        if (op == OP_DIV) begin
          mul_y = bn;
        end else if (is_unary) begin
          mul_y = W'(1);
        end else begin
          mul_y = bd;
        end
      end
      default: begin
        mul_x = an;
        mul_y = bd;
      end
    endcase
  end

  rau_mul #(.W(W)) u_mul (
    .x   (mul_x),
    .y   (mul_y),
    .neg (prod_neg),
    .mag (prod_mag)
  );

  // Dividend of the division in progress and its remainder shifted by one bit.
  assign div_dvd   = (state == S_DIVD) ? den_mag : num_mag;
  assign div_shift = {rem, div_dvd[MW-1]};

  // Shared unit operand selection.
  always_comb begin
    alu_mode = ALU_ABSDIFF;
    alu_x    = UW'(num_mag);
    alu_y    = UW'(q_mag);
    unique case (state)
      S_COMB: begin
        alu_mode = (num_neg == q_neg) ? ALU_ADD : ALU_ABSDIFF;
      end
      S_GCD: begin
        alu_x = UW'(u);
        alu_y = UW'(v);
      end
      S_DIVN, S_DIVD: begin
        alu_x = div_shift;
        alu_y = UW'(g);
      end
      default: begin
        alu_mode = ALU_ABSDIFF;
      end
    endcase
  end

  rau_alu #(.UW(UW)) u_alu (
    .mode  (alu_mode),
    .x     (alu_x),
    .y     (alu_y),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // Signed comparison of the two cross products held in sign-magnitude form.
  assign p_neg  = num_neg && (num_mag != '0);
  assign r_neg  = q_neg && (q_mag != '0);
  assign cmp_eq = (p_neg == r_neg) && alu_flags.zero;
  always_comb begin
    if (p_neg != r_neg) begin
      cmp_lt = p_neg;
    end else if (p_neg) begin
      cmp_lt = alu_flags.geq && !alu_flags.zero;
    end else begin
      cmp_lt = !alu_flags.geq;
    end
  end
  always_comb begin
    if (op == OP_LT) begin
      cmp_res = cmp_lt;
    end else if (op == OP_GT) begin
      cmp_res = !cmp_lt && !cmp_eq;
    end else begin
      cmp_res = cmp_eq;
    end
  end

  // Gcd once one of the two values has reached zero.
  assign gcd_val = ((u == '0) ? v : u) << k;

  // Result formatting: low word bits of the signed value, with range check.
  assign out_nneg  = num_neg && (num_mag != '0);
  assign out_dneg  = den_neg;
  assign out_nlow  = out_nneg ? (~num_mag[W-1:0] + W'(1)) : num_mag[W-1:0];
  assign out_dlow  = out_dneg ? (~den_mag[W-1:0] + W'(1)) : den_mag[W-1:0];
  assign top_n     = num_mag[MW-1:W-1];
  assign top_d     = den_mag[MW-1:W-1];
  assign fit_n     = (top_n == '0) ||
                     (out_nneg && (top_n == (W+1)'(1)) && (num_mag[W-2:0] == '0));
  assign fit_d     = (top_d == '0) ||
                     (out_dneg && (top_d == (W+1)'(1)) && (den_mag[W-2:0] == '0));
  always_comb begin
    if (pend_zero) begin
      rsp_build.res_num  = '0;
      rsp_build.res_den  = '0;
      rsp_build.cmp_flag = pend_flag;
      rsp_build.status   = pend_status;
    end else begin
      rsp_build.res_num  = FIELD_BITS'(out_nlow);
      rsp_build.res_den  = FIELD_BITS'(out_dlow);
      rsp_build.cmp_flag = 1'b0;
      rsp_build.status   = (fit_n && fit_d) ? ST_OK : ST_OVERFLOW;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op          <= req.operation;
            an          <= req.a_num[W-1:0];
            ad          <= req.a_den[W-1:0];
            bn          <= req.b_num[W-1:0];
            bd          <= req.b_den[W-1:0];
            pend_flag   <= 1'b0;
            pend_status <= ST_OK;
            pend_zero   <= 1'b1;
            if (req.operation > OP_EQ) begin
              state <= S_FIN;
            end else if ((req.a_den[W-1:0] == '0) ||
                         (!(req.operation == OP_NEG || req.operation == OP_ABS) &&
                          (req.b_den[W-1:0] == '0))) begin
              pend_status <= ST_ZERO_DEN;
              state       <= S_FIN;
            end else begin
              pend_zero <= 1'b0;
              state     <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          num_neg <= prod_neg;
          num_mag <= prod_mag;
          state   <= (is_addsub || is_cmp) ? S_MUL2 : S_MUL3;
        end
        S_MUL2: begin
          // Subtraction negates the second cross product unless it is zero.
          q_neg <= prod_neg ^ ((op == OP_SUB) && (prod_mag != '0));
          q_mag <= prod_mag;
          state <= is_cmp ? S_CMP : S_MUL3;
        end
        S_MUL3: begin
          den_neg <= prod_neg;
          den_mag <= prod_mag;
          state   <= is_addsub ? S_COMB : S_PREP;
        end
        S_COMB: begin
          num_mag <= alu_res[MW-1:0];
          if (alu_res == '0) begin
            num_neg <= 1'b0;
          end else if ((num_neg != q_neg) && !alu_flags.geq) begin
            num_neg <= q_neg;
          end
          state <= S_PREP;
        end
        S_CMP: begin
          pend_zero <= 1'b1;
          pend_flag <= cmp_res;
          state     <= S_FIN;
        end
        S_PREP: begin
          if (den_mag == '0) begin
            pend_zero   <= 1'b1;
            pend_status <= ST_ZERO_DEN;
            state       <= S_FIN;
          end else begin
            // Absolute value: flip the numerator when the value is negative.
            if ((op == OP_ABS) && (num_mag != '0) && (num_neg != den_neg)) begin
              num_neg <= !num_neg;
            end
            u     <= num_mag;
            v     <= den_mag;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // One binary gcd step: a common halving, a single halving or a subtraction.
          priority if ((u == '0) || (v == '0)) begin
            g   <= gcd_val;
            rem <= '0;
            cnt <= '0;
            state <= (gcd_val == MW'(1)) ? S_FIN : S_DIVN;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + KW'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (alu_flags.geq) begin
            u <= alu_res[MW-1:0];
          end else begin
            v <= alu_res[MW-1:0];
          end
        end
        S_DIVN, S_DIVD: begin
          // Restoring division: one quotient bit a cycle, shifted into the dividend.
          if (alu_flags.geq) begin
            rem <= alu_res[MW-1:0];
          end else begin
            rem <= div_shift[MW-1:0];
          end
          if (state == S_DIVN) begin
            num_mag <= {num_mag[MW-2:0], alu_flags.geq};
          end else begin
            den_mag <= {den_mag[MW-2:0], alu_flags.geq};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MW - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= (state == S_DIVN) ? S_DIVD : S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && slot_free) begin
      rsp <= rsp_build;
    end
  end

  // Assertions.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, req_stall)
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst, (state == S_DIVN) || (state == S_DIVD), g != '0)
  `ASSERT_IMPLIES(a_zero_den_clean, clk, rst, rsp_valid && (rsp.status == ST_ZERO_DEN), (rsp.res_num == '0) && (rsp.res_den == '0) && !rsp.cmp_flag)
  `ASSERT_IMPLIES(a_flag_only_cmp, clk, rst, rsp_valid && rsp.cmp_flag, (rsp.status == ST_OK) && (rsp.res_den == '0))

endmodule
`default_nettype wire

// ----- sim/rau_monitor.sv -----
// Monitor for the rational arithmetic unit: predicts each result and compares it on arrival.
module rau_monitor import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  rau_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  rau_rsp_t rsp,
  output int       mismatches,
  output int       checked,
  output int       zero_dens,
  output int       overflows
);

  localparam logic [63:0] WORD_MASK  = (64'd1 << WORD_BITS) - 64'd1;
  localparam logic [63:0] HALF_RANGE = 64'd1 << (WORD_BITS - 1);
  localparam int REPORT_LIMIT = 20;

  // A value held as a sign and a 64-bit magnitude.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } signed_mag_t;

  // Results still owed by the unit, oldest first, with the items that caused them.
  rau_rsp_t due_results[$];
  rau_req_t due_items[$];

  // The component as the unit sees it: the low WORD_BITS bits, two's complement.
  function automatic longint word_value(logic [31:0] v);
    logic [63:0] w;
    w = {32'd0, v} & WORD_MASK;
    if (w[WORD_BITS-1]) return longint'(w) - longint'(64'd1 << WORD_BITS);
    return longint'(w);
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    logic [63:0] u;
    u = x;
    return (x < 0) ? -u : u;
  endfunction

  function automatic signed_mag_t sm_product(longint x, longint y);
    signed_mag_t r;
    r.neg = (x < 0) != (y < 0);
    r.mag = magnitude(x) * magnitude(y);
    return r;
  endfunction

  // Signed sum in sign and magnitude form; a zero sum is always positive.
  function automatic signed_mag_t sm_sum(signed_mag_t p, signed_mag_t q);
    signed_mag_t r;
    if (p.neg == q.neg) begin
      r.neg = p.neg;
      r.mag = p.mag + q.mag;
    end else if (p.mag >= q.mag) begin
      r.neg = p.neg;
      r.mag = p.mag - q.mag;
    end else begin
      r.neg = q.neg;
      r.mag = q.mag - p.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit fits_word(signed_mag_t v);
    return v.neg ? (v.mag <= HALF_RANGE) : (v.mag < HALF_RANGE);
  endfunction

  // Low WORD_BITS bits of the value, sign-extended to the port width.
  function automatic logic [31:0] port_word(signed_mag_t v);
    logic [63:0] w;
    w = (v.neg ? -v.mag : v.mag) & WORD_MASK;
    if (w[WORD_BITS-1]) w = w | ~WORD_MASK;
    return w[31:0];
  endfunction

  // Works out the reduced result, or the comparison flag, for one item.
  function automatic rau_rsp_t reduced_result(rau_req_t r);
    longint an, ad, bn, bd, lhs, rhs;
    signed_mag_t num, den, q;
    logic [63:0] g;
    rau_rsp_t o;
    o = '0;
    an = word_value(r.a_num);
    ad = word_value(r.a_den);
    bn = word_value(r.b_num);
    bd = word_value(r.b_den);
    if (r.operation > OP_EQ) return o;
    // An operand with a zero denominator is no rational; unary operations read only a.
    if (ad == 0 || ((r.operation <= OP_DIV || r.operation >= OP_LT) && bd == 0)) begin
      o.status = ST_ZERO_DEN;
      return o;
    end
    if (r.operation >= OP_LT) begin
      lhs = an * bd;
      rhs = bn * ad;
      case (r.operation)
        OP_LT:   o.cmp_flag = lhs < rhs;
        OP_GT:   o.cmp_flag = lhs > rhs;
        default: o.cmp_flag = lhs == rhs;
      endcase
      return o;
    end
    case (r.operation)
      OP_ADD, OP_SUB: begin
        num = sm_product(an, bd);
        q = sm_product(bn, ad);
        if (r.operation == OP_SUB && q.mag != 0) q.neg = !q.neg;
        num = sm_sum(num, q);
        den = sm_product(ad, bd);
      end
      OP_MUL: begin
        num = sm_product(an, bn);
        den = sm_product(ad, bd);
      end
      OP_DIV: begin
        num = sm_product(an, bd);
        den = sm_product(ad, bn);
      end
      OP_NEG: begin
        num = sm_product(an, -1);
        den = sm_product(ad, 1);
      end
      default: begin
        // Absolute value flips the numerator only when the signs differ.
        num = sm_product(an, 1);
        den = sm_product(ad, 1);
        if (num.mag != 0 && num.neg != den.neg) num.neg = !num.neg;
      end
    endcase
    if (den.mag == 0) begin
      o.status = ST_ZERO_DEN;
      return o;
    end
    // Reduce by the gcd of the magnitudes; both signs stay as computed, but a zero numerator is made positive.
    g = common_divisor(num.mag, den.mag);
    num.mag = num.mag / g;
    den.mag = den.mag / g;
    if (num.mag == 0) num.neg = 1'b0;
    o.res_num = port_word(num);
    o.res_den = port_word(den);
    o.status = (fits_word(num) && fits_word(den)) ? ST_OK : ST_OVERFLOW;
    return o;
  endfunction

  // Record a prediction for each accepted item and compare each accepted result.
  always @(posedge clk) begin : watch
    rau_rsp_t want;
    rau_req_t cause;
    logic [3:0] diff;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = reduced_result(req);
        due_results.push_back(want);
        due_items.push_back(req);
        if (want.status == ST_ZERO_DEN) zero_dens++;
        if (want.status == ST_OVERFLOW) overflows++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no item outstanding: num %0d den %0d flag %0b status %0d",
                     $time, rsp.res_num, rsp.res_den, rsp.cmp_flag, rsp.status);
        end else begin
          want = due_results.pop_front();
          cause = due_items.pop_front();
          checked++;
          diff = {rsp.res_num !== want.res_num, rsp.res_den !== want.res_den,
                  rsp.cmp_flag !== want.cmp_flag, rsp.status !== want.status};
          if (diff != 4'b0000) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: wrong result for op %0d a=%0d/%0d b=%0d/%0d (num,den,flag,status %b)",
                       $time, cause.operation, cause.a_num, cause.a_den, cause.b_num,
                       cause.b_den, diff);
              $display("  expected num %0d den %0d flag %0b status %0d, got num %0d den %0d flag %0b status %0d",
                       want.res_num, want.res_den, want.cmp_flag, want.status,
                       rsp.res_num, rsp.res_den, rsp.cmp_flag, rsp.status);
            end
          end
        end
      end
    end
  end

endmodule

// ----- sim/rational_arith_unit_test.sv -----
// Testbench top for the rational arithmetic unit: clock, reset, stimulus and verdict.
module rational_arith_unit_test;
  import rau_pkg::*;

  localparam int WORD_BITS    = 32;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES  = 1200;
  localparam int QUIET_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 16 * WORD_BITS + 40;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;
  localparam int HOLD_AT_1    = 300;
  localparam int HOLD_AT_2    = 1400;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  rau_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  rau_rsp_t rsp;

  int sent_count;
  int mismatches;
  int checked;
  int zero_dens;
  int overflows;

  rational_arith_unit #(.WORD_BITS(WORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  rau_monitor #(.WORD_BITS(WORD_BITS)) monitor (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (mismatches),
    .checked    (checked),
    .zero_dens  (zero_dens),
    .overflows  (overflows)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both sides run without gaps for a stretch of items in the middle of the run.
  function automatic bit idle_allowed();
    return sent_count < CALM_FIRST || sent_count >= CALM_LAST;
  endfunction

  function automatic rau_req_t make_req(logic [3:0] op,
                                        logic signed [31:0] an, ad, bn, bd);
    rau_req_t r;
    r.operation = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    return r;
  endfunction

  // Mostly small components, so that reductions and equal values are common.
  function automatic logic signed [31:0] random_part();
    int unsigned kind;
    logic [15:0] h;
    logic signed [31:0] v;
    kind = $urandom_range(99);
    if (kind < 45) begin
      v = $urandom_range(40);
      v = v - 20;
    end else if (kind < 70) begin
      h = 16'($urandom);
      v = {{16{h[15]}}, h};
    end else if (kind < 92) begin
      v = $urandom;
    end else begin
      case ($urandom_range(4))
        0:       v = MOST_NEG;
        1:       v = MOST_POS;
        2:       v = 0;
        3:       v = 1;
        default: v = -1;
      endcase
    end
    return v;
  endfunction

  // Offers one item, with an occasional gap first, and waits until it is taken.
  task automatic offer_item(input rau_req_t item);
    while (idle_allowed() && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  // Receiver: random stalls, plus two long hold-offs so that the unit backs up.
  initial begin : receiver
    int holds_done;
    int n;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < 2 && sent_count >= ((holds_done == 0) ? HOLD_AT_1 : HOLD_AT_2)) begin
        holds_done++;
        rsp_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      rsp_stall <= idle_allowed() && ($urandom_range(99) < 30);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("rational_arith_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    rau_req_t plan[$];
    rau_req_t item;
    logic signed [31:0] scale;

    // Directed items: every operation, the field extremes and the special cases.
    plan.push_back(make_req(OP_ADD, 1, 2, 1, 3));
    plan.push_back(make_req(OP_SUB, 1, 2, 1, 2));
    plan.push_back(make_req(OP_MUL, 3, -4, 2, 3));
    plan.push_back(make_req(OP_DIV, 1, 2, 0, 5));
    plan.push_back(make_req(OP_DIV, -6, 4, 3, -8));
    plan.push_back(make_req(OP_NEG, MOST_NEG, 1, 0, 0));
    plan.push_back(make_req(OP_NEG, 0, -6, 0, 0));
    plan.push_back(make_req(OP_ABS, 5, -7, 0, 0));
    plan.push_back(make_req(OP_ABS, -5, 7, 0, 0));
    plan.push_back(make_req(OP_ABS, MOST_NEG, -3, 1, 1));
    plan.push_back(make_req(OP_LT, 1, 2, 2, 3));
    plan.push_back(make_req(OP_GT, -1, 2, 1, -3));
    plan.push_back(make_req(OP_EQ, 1, 2, 2, 4));
    plan.push_back(make_req(OP_EQ, 1, 2, -1, -2));
    plan.push_back(make_req(OP_LT, 1, 2, 3, 0));
    plan.push_back(make_req(OP_ADD, 1, 0, 1, 1));
    plan.push_back(make_req(OP_ADD, 1, 1, 1, 0));
    plan.push_back(make_req(OP_NEG, 3, 4, 7, 0));
    plan.push_back(make_req(OP_ABS, 3, 0, 1, 1));
    plan.push_back(make_req(OP_EQ + 4'd1, 1, 2, 3, 4));
    plan.push_back(make_req(4'hf, -1, -1, -1, -1));
    plan.push_back(make_req(OP_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
    plan.push_back(make_req(OP_ADD, MOST_POS, 1, MOST_POS, 1));
    plan.push_back(make_req(OP_SUB, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG));
    plan.push_back(make_req(OP_DIV, -1, -1, MOST_NEG, MOST_POS));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) offer_item(plan[i]);

    // Random items; comparisons often get a scaled copy of a so that equality is hit.
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(99) < 4) item.operation = 4'($urandom_range(15, OP_EQ + 1));
      else item.operation = 4'($urandom_range(OP_EQ));
      item.a_num = random_part();
      item.a_den = random_part();
      item.b_num = random_part();
      item.b_den = random_part();
      if (item.operation >= OP_LT && item.operation <= OP_EQ && $urandom_range(2) == 0) begin
        scale = $urandom_range(4, 1);
        if ($urandom_range(1) == 1) scale = -scale;
        item.b_num = item.a_num * scale;
        item.b_den = item.a_den * scale;
      end
      offer_item(item);
    end
    req_valid <= 1'b0;

    // Wait for every result, then a little longer in case an extra one turns up.
    while (checked < sent_count) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d items across all operations and unused codes,",
             checked, sent_count);
    $display("with %0d zero-denominator and %0d overflow results and two long output hold-offs.",
             zero_dens, overflows);
    if (mismatches == 0) $display("rational_arith_unit: match");
    else $display("rational_arith_unit: mismatch");
    $finish;
  end

endmodule
